@@ sv/nfes_pkg.sv @@
// Shared codes, field widths and the store control group for the event slot pool.
package nfes_pkg;

    // Fixed field widths of the command and response words.
    localparam int OP_W     = 2;
    localparam int ID_W     = 8;
    localparam int DATA_W   = 32;
    localparam int SLOTN_W  = 4;
    localparam int STATUS_W = 2;

    // Default pool geometry.
    localparam int SLOTS_DEFAULT   = 16;
    localparam int ID_BITS_DEFAULT = 8;

    typedef logic [OP_W-1:0]     op_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Operation codes.
    localparam op_t OP_CREATE = 2'd0;
    localparam op_t OP_DELETE = 2'd1;
    localparam op_t OP_READ   = 2'd2;

    // Status codes.
    localparam status_t ST_OK     = 2'd0;
    localparam status_t ST_BAD_ID = 2'd1;
    localparam status_t ST_FULL   = 2'd2;

    // Control strobes from the sequencer to the slot store.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr_en;
    } store_ctl_t;

endpackage

@@ sv/nfes_ifs.sv @@
// Command and response channel interfaces of the event slot pool.
interface nfes_cmd_if;
    import nfes_pkg::*;

    logic                 valid;
    logic                 ready;
    op_t                  operation;
    logic [ID_W-1:0]      event_code;
    logic [DATA_W-1:0]    event_attr;
    logic [DATA_W-1:0]    event_word;
    logic [SLOTN_W-1:0]   slot_number;

    modport source (
        output valid, operation, event_code, event_attr, event_word, slot_number,
        input  ready
    );
    modport sink (
        input  valid, operation, event_code, event_attr, event_word, slot_number,
        output ready
    );
endinterface

interface nfes_rsp_if;
    import nfes_pkg::*;

    logic                 valid;
    logic                 ready;
    status_t              status;
    logic [SLOTN_W-1:0]   granted_slot;
    logic [ID_W-1:0]      read_id;
    logic [DATA_W-1:0]    read_flags;
    logic [DATA_W-1:0]    read_word;

    modport source (
        output valid, status, granted_slot, read_id, read_flags, read_word,
        input  ready
    );
    modport sink (
        input  valid, status, granted_slot, read_id, read_flags, read_word,
        output ready
    );
endinterface

@@ sv/nfes_store.sv @@
// Slot store: synchronous entry memory with per-slot valid bits cleared at reset.
module nfes_store #(
    parameter int SLOTS   = nfes_pkg::SLOTS_DEFAULT,
    parameter int ENTRY_W = 72
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  nfes_pkg::store_ctl_t     ctl,
    input  logic [$clog2(SLOTS)-1:0] addr,
    input  logic [ENTRY_W-1:0]       wr_data,
    output logic [ENTRY_W-1:0]       rd_data,
    output logic                     rd_valid
);
    import nfes_pkg::*;

    logic [ENTRY_W-1:0] mem [SLOTS];
    logic [ENTRY_W-1:0] q_reg;
    logic [SLOTS-1:0]   valid_reg;
    logic               vq_reg;

    // Entry memory: one access per cycle, registered read data.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            q_reg <= mem[addr];
        end
    end

    // Valid bits: an entry never written since reset, or deleted, reads as free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            vq_reg    <= 1'b0;
        end
        else
        begin
            if (ctl.wr_en)
            begin
                valid_reg[addr] <= 1'b1;
            end
            else if (ctl.clr_en)
            begin
                valid_reg[addr] <= 1'b0;
            end
            if (ctl.rd_en)
            begin
                vq_reg <= valid_reg[addr];
            end
        end
    end

    // A cleared entry reads back as all zero.
    assign rd_valid = vq_reg;
    assign rd_data  = vq_reg ? q_reg : '0;

endmodule

@@ sv/next_fit_event_slot_pool.sv @@
// Top level of the next-fit event slot pool: sequencer, result register and store.
//
//  Channel | Dir | Word contents
//  --------+-----+----------------------------------------------------------
//  cmd     | in  | operation, event_code, event_attr, event_word, slot_number
//  rsp     | out | status, granted_slot, read_id, read_flags, read_word
//
// One command is in flight at a time. A delete, a rejected create or an
// out-of-range read goes straight to the response, a read waits for the
// slot data, and a create scans one slot per cycle through the single port of the slot memory.
// The response then sits in the output register until rsp.ready, and the next
// command is taken in the cycle after it leaves. Reset clears all slot valid bits
// at once, so the pool is empty and ready right after reset.
module next_fit_event_slot_pool #(
    parameter int SLOTS   = nfes_pkg::SLOTS_DEFAULT,
    parameter int ID_BITS = nfes_pkg::ID_BITS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    nfes_cmd_if.sink      cmd,
    nfes_rsp_if.source    rsp
);
    import nfes_pkg::*;

    localparam int SLOT_BITS = $clog2(SLOTS);
    localparam int WIDE_W    = (SLOT_BITS + 1 > SLOTN_W + 1) ? SLOT_BITS + 1 : SLOTN_W + 1;
    localparam int IDS_W     = (ID_BITS < ID_W) ? ID_BITS : ID_W;
    localparam int ENTRY_W   = IDS_W + 2 * DATA_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(SLOTS - 1);

    logic [1:0]            state_reg, state_next;
    logic [SLOT_BITS-1:0]  start_reg, start_next;
    logic [SLOT_BITS-1:0]  cur_reg, cur_next;
    logic [SLOT_BITS-1:0]  tried_reg, tried_next;
    logic [IDS_W-1:0]      id_reg, id_next;
    logic [DATA_W-1:0]     flags_reg, flags_next;
    logic [DATA_W-1:0]     word_reg, word_next;
    status_t               status_reg, status_next;
    logic [SLOTN_W-1:0]    granted_reg, granted_next;
    logic [ID_W-1:0]       rid_reg, rid_next;
    logic [DATA_W-1:0]     rflags_reg, rflags_next;
    logic [DATA_W-1:0]     rword_reg, rword_next;

    store_ctl_t            ctl;
    logic [SLOT_BITS-1:0]  addr;
    logic [ENTRY_W-1:0]    rd_data;
    logic                  rd_valid;

    logic                  accept;
    logic [IDS_W-1:0]      id_cut;
    logic [WIDE_W-1:0]     slot_wide;
    logic                  in_range;
    logic [SLOT_BITS-1:0]  slot_idx;
    logic [SLOT_BITS-1:0]  cur_inc;

    // Command decode helpers.
    assign accept    = cmd.valid && cmd.ready;
    assign id_cut    = cmd.event_code[IDS_W-1:0];
    assign slot_wide = WIDE_W'(cmd.slot_number);
    assign in_range  = slot_wide < WIDE_W'(SLOTS);
    assign slot_idx  = slot_wide[SLOT_BITS-1:0];
    assign cur_inc   = (cur_reg == LAST_SLOT) ? '0 : cur_reg + 1'b1;

    // Sequencer: decode, next-fit scan, read wait and response hold.
    always_comb
    begin
        state_next   = state_reg;
        start_next   = start_reg;
        cur_next     = cur_reg;
        tried_next   = tried_reg;
        id_next      = id_reg;
        flags_next   = flags_reg;
        word_next    = word_reg;
        status_next  = status_reg;
        granted_next = granted_reg;
        rid_next     = rid_reg;
        rflags_next  = rflags_reg;
        rword_next   = rword_reg;
        ctl          = '0;
        addr         = slot_idx;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next  = ST_OK;
                    granted_next = '0;
                    rid_next     = '0;
                    rflags_next  = '0;
                    rword_next   = '0;
                    state_next   = S_DONE;
                    case (cmd.operation)
                        OP_CREATE:
                        begin
                            if (id_cut == '0)
                            begin
                                status_next = ST_BAD_ID;
                            end
                            else
                            begin
                                addr       = start_reg;
                                ctl.rd_en  = 1'b1;
                                cur_next   = start_reg;
                                tried_next = '0;
                                id_next    = id_cut;
                                flags_next = cmd.event_attr;
                                word_next  = cmd.event_word;
                                state_next = S_SCAN;
                            end
                        end
                        OP_DELETE:
                        begin
                            ctl.clr_en = in_range;
                        end
                        OP_READ:
                        begin
                            if (in_range)
                            begin
                                ctl.rd_en  = 1'b1;
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (!rd_valid)
                begin
                    // Free slot found: take it and leave the search index on it.
                    addr         = cur_reg;
                    ctl.wr_en    = 1'b1;
                    start_next   = cur_reg;
                    granted_next = SLOTN_W'(cur_reg);
                    state_next   = S_DONE;
                end
                else if (tried_reg == LAST_SLOT)
                begin
                    // Every slot visited: the index stands on the slot just before its start.
                    status_next = ST_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    addr       = cur_inc;
                    ctl.rd_en  = 1'b1;
                    cur_next   = cur_inc;
                    tried_next = tried_reg + 1'b1;
                end
            end
            S_READ:
            begin
                rid_next    = ID_W'(rd_data[ENTRY_W-1 -: IDS_W]);
                rflags_next = rd_data[2*DATA_W-1 -: DATA_W];
                rword_next  = rd_data[DATA_W-1:0];
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            start_reg <= '0;
            cur_reg   <= '0;
            tried_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= start_next;
            cur_reg   <= cur_next;
            tried_reg <= tried_next;
        end
    end

    // Payload and response registers.
    always_ff @(posedge clk)
    begin
        id_reg      <= id_next;
        flags_reg   <= flags_next;
        word_reg    <= word_next;
        status_reg  <= status_next;
        granted_reg <= granted_next;
        rid_reg     <= rid_next;
        rflags_reg  <= rflags_next;
        rword_reg   <= rword_next;
    end

    nfes_store #(
        .SLOTS   (SLOTS),
        .ENTRY_W (ENTRY_W)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .addr     (addr),
        .wr_data  ({id_reg, flags_reg, word_reg}),
        .rd_data  (rd_data),
        .rd_valid (rd_valid)
    );

    // Channel outputs.
    assign cmd.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = (state_reg == S_DONE);
    assign rsp.status       = status_reg;
    assign rsp.granted_slot = granted_reg;
    assign rsp.read_id      = rid_reg;
    assign rsp.read_flags   = rflags_reg;
    assign rsp.read_word    = rword_reg;

    // The store sees at most one kind of access per cycle.
    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.rd_en, ctl.wr_en, ctl.clr_en}))
        else $error("store read, write and clear overlap");

    // A slot taken by a create becomes the next search start.
    a_start_follows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.wr_en |=> start_reg == $past(cur_reg))
        else $error("search index not left on the taken slot");

    // Only one command is in flight.
    a_single_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !cmd.ready)
        else $error("command taken while another is in flight");

endmodule
